// File: design/wfps_pkg.sv
// Shared types, register codes and reset values of the wall-following steering unit.
package wfps_pkg;

   localparam int unsigned CSR_INDEX_WIDTH = 4;
   localparam int unsigned CSR_DATA_WIDTH  = 16;
   localparam int unsigned QUEUE_DEPTH     = 2;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_GAIN_P         = 4'd0,
      CSR_GAIN_I         = 4'd1,
      CSR_GAIN_D         = 4'd2,
      CSR_INTEGRAL_LIMIT = 4'd3,
      CSR_OUTPUT_LIMIT   = 4'd4,
      CSR_BASE_SPEED     = 4'd5,
      CSR_EDGE_THRESHOLD = 4'd6,
      CSR_END_DISTANCE   = 4'd7
   } csr_index_type;

   typedef enum logic {
      KIND_TICK  = 1'b0,
      KIND_START = 1'b1
   } kind_type;

   typedef struct packed {
      logic [15:0] gain_p;
      logic [15:0] gain_i;
      logic [15:0] gain_d;
      logic [9:0]  integral_limit;
      logic [6:0]  output_limit;
      logic [9:0]  base_speed;
      logic [11:0] edge_threshold;
      logic [12:0] end_distance;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      gain_p:         16'd77,
      gain_i:         16'd0,
      gain_d:         16'd30720,
      integral_limit: 10'd100,
      output_limit:   7'd25,
      base_speed:     10'd500,
      edge_threshold: 12'd100,
      end_distance:   13'd80
   };

   // Status that rides along with an item through the back end.
   typedef struct packed {
      logic drive;
      logic end_now;
      logic paused;
   } meta_type;

   // One classified item as handed from the front end to the back end.
   typedef struct packed {
      meta_type           meta;
      logic signed [12:0] err;
      logic signed [10:0] error_sum;
      logic signed [13:0] deriv;
   } work_type;

endpackage

// File: design/wfps_req_if.sv
// Request channel interface: sensor tick or start command.
interface wfps_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [11:0] left_ir;
   logic [11:0] right_ir;
   logic [12:0] front_distance;

   modport source (output valid, output kind, output left_ir, output right_ir,
                   output front_distance, input ready);
   modport sink   (input valid, input kind, input left_ir, input right_ir,
                   input front_distance, output ready);
endinterface

// File: design/wfps_rsp_if.sv
// Response channel interface: wheel speed command and navigation status.
interface wfps_rsp_if;
   logic               valid;
   logic               ready;
   logic               drive_valid;
   logic signed [11:0] left_speed;
   logic signed [11:0] right_speed;
   logic               corridor_end;
   logic               paused;

   modport source (output valid, output drive_valid, output left_speed,
                   output right_speed, output corridor_end, output paused,
                   input ready);
   modport sink   (input valid, input drive_valid, input left_speed,
                   input right_speed, input corridor_end, input paused,
                   output ready);
endinterface

// File: design/wfps_front.sv
// Front end: accept items, track navigation and PID memory, classify for the back end.
module wfps_front (
   input  logic               clock,
   input  logic               reset,
   input  wfps_pkg::cfg_type  cfg,
   wfps_req_if.sink           req_ch,
   input  logic               queue_full,
   output logic               push,
   output wfps_pkg::work_type push_data
);

   logic signed [10:0] error_sum_ff, error_sum_in;
   logic signed [12:0] prev_error_ff, prev_error_in;
   logic               navigating_ff, navigating_in;

   logic signed [12:0] err;
   logic signed [13:0] deriv;
   logic signed [13:0] sum_raw;
   logic signed [13:0] sum_lim;
   logic signed [10:0] sum_clamped;
   logic               end_now;
   logic               accept;
   logic               is_start;

   assign req_ch.ready = !queue_full;

   always_comb begin
      accept   = req_ch.valid && req_ch.ready;
      is_start = (req_ch.kind == wfps_pkg::KIND_START);

      err     = $signed({1'b0, req_ch.left_ir}) - $signed({1'b0, req_ch.right_ir});
      deriv   = 14'(err) - 14'(prev_error_ff);
      sum_raw = 14'(error_sum_ff) + 14'(err);
      sum_lim = $signed({4'b0000, cfg.integral_limit});

      // clamp the accumulated error symmetrically
      if (sum_raw > sum_lim) begin
         sum_clamped = 11'(sum_lim);
      end else if (sum_raw < -sum_lim) begin
         sum_clamped = 11'(-sum_lim);
      end else begin
         sum_clamped = 11'(sum_raw);
      end

      end_now = (req_ch.left_ir < cfg.edge_threshold) ||
                (req_ch.right_ir < cfg.edge_threshold) ||
                (req_ch.front_distance <= cfg.end_distance);

      error_sum_in  = error_sum_ff;
      prev_error_in = prev_error_ff;
      navigating_in = navigating_ff;

      push_data.meta.drive   = 1'b0;
      push_data.meta.end_now = 1'b0;
      push_data.meta.paused  = !navigating_ff;
      push_data.err          = err;
      push_data.error_sum    = sum_clamped;
      push_data.deriv        = deriv;

      if (is_start) begin
         push_data.meta.paused = 1'b0;
         if (accept) begin
            navigating_in = 1'b1;
         end
      end else if (navigating_ff) begin
         push_data.meta.drive   = 1'b1;
         push_data.meta.end_now = end_now;
         push_data.meta.paused  = end_now;
         if (accept) begin
            error_sum_in  = sum_clamped;
            prev_error_in = err;
            navigating_in = !end_now;
         end
      end
   end

   assign push = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         error_sum_ff  <= '0;
         prev_error_ff <= '0;
         navigating_ff <= 1'b0;
      end else begin
         error_sum_ff  <= error_sum_in;
         prev_error_ff <= prev_error_in;
         navigating_ff <= navigating_in;
      end
   end

   a_start_navigates: assert property (@(posedge clock) disable iff (reset)
      (accept && is_start) |=> navigating_ff)
      else $error("start transfer did not enable navigation");

   a_end_pauses: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_start && navigating_ff && end_now) |=> !navigating_ff)
      else $error("corridor end did not pause navigation");

endmodule

// File: design/wfps_queue.sv
// Short FIFO between the front end and the back end.
module wfps_queue #(
   parameter int unsigned Depth = wfps_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wfps_pkg::work_type push_data,
   output logic               full,
   input  logic               pop,
   output wfps_pkg::work_type pop_data,
   output logic               empty
);

   localparam int unsigned PtrWidth   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned CountWidth = $clog2(Depth + 1);
   localparam logic [PtrWidth-1:0]   LastPtr   = PtrWidth'(Depth - 1);
   localparam logic [CountWidth-1:0] FullCount = CountWidth'(Depth);

   wfps_pkg::work_type    entries_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      unique case ({push, pop})
         2'b10:   count_in = count_ff + CountWidth'(1);
         2'b01:   count_in = count_ff - CountWidth'(1);
         default: count_in = count_ff;
      endcase
   end

   assign full     = (count_ff == FullCount);
   assign empty    = (count_ff == '0);
   assign pop_data = entries_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("front end pushed into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && empty))
      else $error("back end popped an empty queue");

endmodule

// File: design/wfps_back.sv
// Back end: PID products, Q8.8 scaling, correction clamp and wheel speeds.
module wfps_back (
   input  logic               clock,
   input  logic               reset,
   input  wfps_pkg::cfg_type  cfg,
   input  logic               empty,
   input  wfps_pkg::work_type pop_data,
   output logic               pop,
   wfps_rsp_if.source         rsp_ch
);

   logic                pipe_en;

   // product stage
   logic                s1_valid_ff;
   wfps_pkg::meta_type  s1_meta_ff;
   logic signed [28:0]  prod_p_ff, prod_p_in;
   logic signed [27:0]  prod_i_ff, prod_i_in;
   logic signed [29:0]  prod_d_ff, prod_d_in;

   // sum stage
   logic                s2_valid_ff;
   wfps_pkg::meta_type  s2_meta_ff;
   logic signed [30:0]  acc_ff, acc_in;

   // scale and clamp stage
   logic                s3_valid_ff;
   wfps_pkg::meta_type  s3_meta_ff;
   logic signed [7:0]   corr_ff, corr_in;
   logic signed [30:0]  biased;
   logic signed [22:0]  quot;
   logic signed [22:0]  out_lim;

   // output register
   logic                rsp_valid_ff;
   logic                rsp_drive_ff;
   logic signed [11:0]  rsp_left_ff, rsp_left_in;
   logic signed [11:0]  rsp_right_ff, rsp_right_in;
   logic                rsp_end_ff;
   logic                rsp_paused_ff;

   always_comb begin
      // advance the whole back end unless a result is held at the output
      pipe_en = !rsp_valid_ff || rsp_ch.ready;
      pop     = pipe_en && !empty;

      prod_p_in = $signed({1'b0, cfg.gain_p}) * pop_data.err;
      prod_i_in = $signed({1'b0, cfg.gain_i}) * pop_data.error_sum;
      prod_d_in = $signed({1'b0, cfg.gain_d}) * pop_data.deriv;

      acc_in = 31'(prod_p_ff) + 31'(prod_i_ff) + 31'(prod_d_ff);

      // divide by 256 rounding toward zero
      biased  = acc_ff + (acc_ff[30] ? 31'sd255 : 31'sd0);
      quot    = $signed(biased[30:8]);
      out_lim = $signed({16'b0, cfg.output_limit});
      if (quot > out_lim) begin
         corr_in = 8'(out_lim);
      end else if (quot < -out_lim) begin
         corr_in = 8'(-out_lim);
      end else begin
         corr_in = 8'(quot);
      end

      if (s3_meta_ff.drive) begin
         rsp_left_in  = $signed({2'b00, cfg.base_speed}) + 12'(corr_ff);
         rsp_right_in = $signed({2'b00, cfg.base_speed}) - 12'(corr_ff);
      end else begin
         rsp_left_in  = '0;
         rsp_right_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (pipe_en) begin
         s1_valid_ff  <= !empty;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         rsp_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pipe_en) begin
         s1_meta_ff    <= pop_data.meta;
         prod_p_ff     <= prod_p_in;
         prod_i_ff     <= prod_i_in;
         prod_d_ff     <= prod_d_in;
         s2_meta_ff    <= s1_meta_ff;
         acc_ff        <= acc_in;
         s3_meta_ff    <= s2_meta_ff;
         corr_ff       <= corr_in;
         rsp_drive_ff  <= s3_meta_ff.drive;
         rsp_left_ff   <= rsp_left_in;
         rsp_right_ff  <= rsp_right_in;
         rsp_end_ff    <= s3_meta_ff.end_now;
         rsp_paused_ff <= s3_meta_ff.paused;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.drive_valid  = rsp_drive_ff;
   assign rsp_ch.left_speed   = rsp_left_ff;
   assign rsp_ch.right_speed  = rsp_right_ff;
   assign rsp_ch.corridor_end = rsp_end_ff;
   assign rsp_ch.paused       = rsp_paused_ff;

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_drive_ff) |->
         (rsp_left_ff == '0 && rsp_right_ff == '0 && !rsp_end_ff))
      else $error("non-drive result carries speeds or end flag");

   a_end_implies_drive_pause: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_end_ff) |-> (rsp_drive_ff && rsp_paused_ff))
      else $error("corridor end without drive and pause");

endmodule

// File: design/wall_following_pid_steering_unit.sv
// Top level of the wall-following PID steering unit.
//
// Corridor-centring steering controller. A start transfer (kind = 1) arms
// navigation and clears the end condition; the PID memory (clamped error sum
// and previous error) is kept across starts. Each tick transfer (kind = 0)
// while navigating forms error = left_ir - right_ir, updates the integral
// clamped to +/- integral_limit, takes the derivative against the last error,
// and computes (gain_p*e + gain_i*sum + gain_d*de) in Q8.8, scaled down by 256
// toward zero and clamped to +/- output_limit. Wheel speeds are base_speed
// plus and minus that correction. A side reading below edge_threshold or a
// front distance at or below end_distance flags corridor_end; that tick still
// drives and navigation pauses after it. Every request produces exactly one
// response; start and paused ticks report drive_valid = 0 with zero speeds.
// Throughput is one transfer per clock while no response is held. The
// transfer edge itself updates the PID memory and writes the two-entry queue,
// then the item passes the back end's product, sum, scale/clamp and output
// registers in that order. A held response
// freezes the whole back end; the front end keeps accepting until the queue
// fills. Registers are written through the csr port (index 0..7 in
// the order gain_p, gain_i, gain_d, integral_limit, output_limit, base_speed,
// edge_threshold, end_distance; other indexes are dropped) and must only be
// written while no request is in flight.
module wall_following_pid_steering_unit #(
   parameter int unsigned QueueDepth = wfps_pkg::QUEUE_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   wfps_req_if.sink                            req_ch,
   wfps_rsp_if.source                          rsp_ch,
   input  logic                                csr_write_enable,
   input  logic [wfps_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [wfps_pkg::CSR_DATA_WIDTH-1:0]  csr_write_data
);

   wfps_pkg::cfg_type  cfg_ff, cfg_in;

   logic               push;
   wfps_pkg::work_type push_data;
   logic               queue_full;
   logic               pop;
   wfps_pkg::work_type pop_data;
   logic               queue_empty;

   // Register file: each write lands in one field, truncated to its width.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (wfps_pkg::csr_index_type'(csr_index))
            wfps_pkg::CSR_GAIN_P:         cfg_in.gain_p         = csr_write_data;
            wfps_pkg::CSR_GAIN_I:         cfg_in.gain_i         = csr_write_data;
            wfps_pkg::CSR_GAIN_D:         cfg_in.gain_d         = csr_write_data;
            wfps_pkg::CSR_INTEGRAL_LIMIT: cfg_in.integral_limit = csr_write_data[9:0];
            wfps_pkg::CSR_OUTPUT_LIMIT:   cfg_in.output_limit   = csr_write_data[6:0];
            wfps_pkg::CSR_BASE_SPEED:     cfg_in.base_speed     = csr_write_data[9:0];
            wfps_pkg::CSR_EDGE_THRESHOLD: cfg_in.edge_threshold = csr_write_data[11:0];
            wfps_pkg::CSR_END_DISTANCE:   cfg_in.end_distance   = csr_write_data[12:0];
            default: begin
               // drop writes to unmapped indexes
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= wfps_pkg::CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Front end: accept, update PID memory and navigation state, classify.
   wfps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .req_ch     (req_ch),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // Decouple the two halves so each can stall on its own.
   wfps_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_data),
      .empty     (queue_empty)
   );

   // Back end: multiply, scale, clamp and form wheel speeds.
   wfps_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .empty    (queue_empty),
      .pop_data (pop_data),
      .pop      (pop),
      .rsp_ch   (rsp_ch)
   );

endmodule
